// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("ipdda assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("ipdda assertion failed");

`endif

// ===== hdl/ipdda_pkg.sv =====
// ----------------------------------------------------------------------------
// ipdda_pkg
// Types and constants of the isometric DDA line rasterizer.
// ----------------------------------------------------------------------------
package ipdda_pkg;

    // field widths
    localparam int COL_W   = 10;
    localparam int HGT_W   = 16;
    localparam int COLOR_W = 24;
    localparam int PIX_W   = 16;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // datapath widths independent of the fraction size
    localparam int MA_W  = 45;  // multiplier A operand
    localparam int SXY_W = 44;  // centred and scaled grid coordinate
    localparam int SZ_W  = 48;  // scaled height
    localparam int ACC_W = 50;  // projection accumulator

    // cos and sin of 30 degrees, Q2.30
    localparam longint COS_Q30 = 929887576;
    localparam longint SIN_Q30 = 536871121;

    localparam logic [COLOR_W-1:0] WHITE = 24'hFF_FFFF;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    localparam logic [2:0] REG_MAP_WIDTH    = 3'd0;
    localparam logic [2:0] REG_MAP_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_XY_SCALE     = 3'd2;
    localparam logic [2:0] REG_HEIGHT_SCALE = 3'd3;
    localparam logic [2:0] REG_OFFSET_X     = 3'd4;
    localparam logic [2:0] REG_OFFSET_Y     = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROJ,
        ST_DRAIN,
        ST_DIFF,
        ST_ABS,
        ST_MAX,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        PH_X,
        PH_Y,
        PH_Z,
        PH_COS,
        PH_SIN
    } mul_phase_t;

endpackage

// ===== hdl/ipdda_if.sv =====
// ----------------------------------------------------------------------------
// ipdda_cmd_if / ipdda_pix_if
// Valid/ready channels for segment and step requests and for pixel results.
// ----------------------------------------------------------------------------
interface ipdda_cmd_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic        [ipdda_pkg::COL_W-1:0]  start_col;
    logic        [ipdda_pkg::COL_W-1:0]  start_row;
    logic signed [ipdda_pkg::HGT_W-1:0]  start_height;
    logic        [ipdda_pkg::COL_W-1:0]  end_col;
    logic        [ipdda_pkg::COL_W-1:0]  end_row;
    logic signed [ipdda_pkg::HGT_W-1:0]  end_height;
    logic        [ipdda_pkg::COLOR_W-1:0] start_color;

    modport source (
        output valid, kind, start_col, start_row, start_height,
               end_col, end_row, end_height, start_color,
        input  ready
    );
    modport sink (
        input  valid, kind, start_col, start_row, start_height,
               end_col, end_row, end_height, start_color,
        output ready
    );
endinterface

interface ipdda_pix_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 pixel_valid;
    logic signed [ipdda_pkg::PIX_W-1:0]   pixel_x;
    logic signed [ipdda_pkg::PIX_W-1:0]   pixel_y;
    logic        [ipdda_pkg::COLOR_W-1:0] pixel_color;
    logic                                 last_pixel;

    modport source (
        output valid, pixel_valid, pixel_x, pixel_y, pixel_color, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_valid, pixel_x, pixel_y, pixel_color, last_pixel,
        output ready
    );
endinterface

// ===== hdl/iso_projected_dda_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// iso_projected_dda_line_rasterizer
// Isometric projection of height-map segments and DDA pixel walk.
// ----------------------------------------------------------------------------
// A step request (kind 1) posts its result through a single output register:
// pixels leave at one per clock while the output is taken. A load request
// (kind 0) occupies the block until its empty result is posted: ten products
// through one shared multiplier, then the difference, abs and max steps, then
// two restoring divisions of FRAC_BITS + 1 quotient bits each through one
// shared subtract-compare unit.
// Configuration is APB, registers at byte address 4*index.
module iso_projected_dda_line_rasterizer #(
    parameter int FRAC_BITS = 16,
    parameter int MAX_STEPS = 65535
) (
    input  logic                             clk,
    input  logic                             rst_n,
    ipdda_cmd_if.sink                        cmd,
    ipdda_pix_if.source                      pix,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ipdda_pkg::ADDR_W-1:0]     paddr,
    input  logic [ipdda_pkg::DATA_W-1:0]     pwdata,
    output logic [ipdda_pkg::DATA_W-1:0]     prdata,
    output logic                             pready
);

    localparam int MA_W  = ipdda_pkg::MA_W;
    localparam int ACC_W = ipdda_pkg::ACC_W;
    localparam int SXY_W = ipdda_pkg::SXY_W;
    localparam int SZ_W  = ipdda_pkg::SZ_W;
    localparam int PIX_W = ipdda_pkg::PIX_W;
    localparam int CRD_W = PIX_W + FRAC_BITS;
    localparam int MAG_W = PIX_W + FRAC_BITS;
    localparam int DIF_W = MAG_W + 1;
    localparam int REM_W = MAG_W + 1;
    localparam int QUO_W = FRAC_BITS + 1;
    localparam int STP_W = FRAC_BITS + 2;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam int PL_W  = $clog2(MAX_STEPS + 2);
    localparam int MB_W  = (FRAC_BITS + 1 > 16) ? FRAC_BITS + 1 : 16;
    localparam int PR_W  = MA_W + MB_W;

    localparam longint COS_L = (ipdda_pkg::COS_Q30 + (longint'(1) << (29 - FRAC_BITS)))
                               >>> (30 - FRAC_BITS);
    localparam longint SIN_L = (ipdda_pkg::SIN_Q30 + (longint'(1) << (29 - FRAC_BITS)))
                               >>> (30 - FRAC_BITS);
    localparam logic signed [MB_W-1:0] COS_C = MB_W'(COS_L);
    localparam logic signed [MB_W-1:0] SIN_C = MB_W'(SIN_L);
    localparam logic [PIX_W-1:0]       MAX_N = PIX_W'(MAX_STEPS);

    // configuration
    logic        [10:0] map_width_reg;
    logic        [10:0] map_height_reg;
    logic        [31:0] xy_scale_reg;
    logic signed [31:0] height_scale_reg;
    logic signed [15:0] off_x_reg;
    logic signed [15:0] off_y_reg;

    // sequencer
    ipdda_pkg::state_t     state_reg, state_next;
    ipdda_pkg::mul_phase_t iss_ph_reg, iss_ph_next, tag_ph_reg;
    logic                  iss_pt_reg, tag_pt_reg, prod_valid_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  div_sel_reg;

    // latched segment
    logic        [ipdda_pkg::COL_W-1:0]   col0_reg, row0_reg, col1_reg, row1_reg;
    logic signed [ipdda_pkg::HGT_W-1:0]   h0_reg, h1_reg;
    logic        [ipdda_pkg::COLOR_W-1:0] color_in_reg;

    // projection
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [PR_W-1:0]  prod_reg;
    logic signed [SXY_W-1:0] sx_reg, sy;
    logic signed [MA_W-1:0]  dif_reg, sum_reg;
    logic signed [ACC_W-1:0] zo_reg, acc_x, acc_y;
    logic signed [SZ_W-1:0]  sz;
    logic signed [11:0]      cx2, cy2;

    // walk setup
    logic signed [CRD_W-1:0] cursor_x_reg, cursor_y_reg, end_x_reg, end_y_reg;
    logic signed [DIF_W-1:0] dx_reg, dy_reg;
    logic        [MAG_W-1:0] ax_reg, ay_reg, steps_reg;
    logic                    neg_x_reg, neg_y_reg;
    logic        [REM_W-1:0] rem_reg, rem_next, trial, steps_ext;
    logic        [QUO_W-1:0] quo_reg, quo_next;
    logic                    ge, cnt_last, zero_len;
    logic signed [STP_W-1:0] q_signed, step_x_reg, step_y_reg;
    logic        [PIX_W-1:0] n_raw, n_sat;

    // segment state
    logic [PL_W-1:0]                  pixels_left_reg;
    logic [ipdda_pkg::COLOR_W-1:0]    seg_color_reg;
    logic                             seg_active_reg;
    logic                             pl_last;

    // output register
    logic                             out_valid_reg;
    logic                             out_pv_reg;
    logic signed [PIX_W-1:0]          out_x_reg, out_y_reg;
    logic [ipdda_pkg::COLOR_W-1:0]    out_color_reg;
    logic                             out_last_reg;

    logic slot_free, cmd_ready_int, load_go, step_go, done_go, out_wr, cfg_wr;
    logic [2:0] cfg_idx;

    function automatic logic signed [CRD_W-1:0] sat_crd(input logic signed [ACC_W-1:0] v);
        logic signed [CRD_W-1:0] r;
        if (v[ACC_W-1:CRD_W-1] == {(ACC_W-CRD_W+1){v[ACC_W-1]}})
            r = v[CRD_W-1:0];
        else
            r = {v[ACC_W-1], {(CRD_W-1){~v[ACC_W-1]}}};
        return r;
    endfunction

    function automatic logic signed [PIX_W-1:0] trunc_px(input logic signed [CRD_W-1:0] v);
        logic [PIX_W-1:0] fl;
        logic             up;
        fl = v[CRD_W-1:FRAC_BITS];
        up = v[CRD_W-1] && (|v[FRAC_BITS-1:0]);
        return fl + PIX_W'(up);
    endfunction

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        case (cfg_idx)
            ipdda_pkg::REG_MAP_WIDTH:    prdata = 32'(map_width_reg);
            ipdda_pkg::REG_MAP_HEIGHT:   prdata = 32'(map_height_reg);
            ipdda_pkg::REG_XY_SCALE:     prdata = xy_scale_reg;
            ipdda_pkg::REG_HEIGHT_SCALE: prdata = height_scale_reg;
            ipdda_pkg::REG_OFFSET_X:     prdata = 32'(off_x_reg);
            ipdda_pkg::REG_OFFSET_Y:     prdata = 32'(off_y_reg);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg    <= 11'd1;
            map_height_reg   <= 11'd1;
            xy_scale_reg     <= 32'h0001_0000;
            height_scale_reg <= 32'sh0001_0000;
            off_x_reg        <= '0;
            off_y_reg        <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                ipdda_pkg::REG_MAP_WIDTH:    map_width_reg    <= pwdata[10:0];
                ipdda_pkg::REG_MAP_HEIGHT:   map_height_reg   <= pwdata[10:0];
                ipdda_pkg::REG_XY_SCALE:     xy_scale_reg     <= pwdata;
                ipdda_pkg::REG_HEIGHT_SCALE: height_scale_reg <= pwdata;
                ipdda_pkg::REG_OFFSET_X:     off_x_reg        <= pwdata[15:0];
                ipdda_pkg::REG_OFFSET_Y:     off_y_reg        <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign slot_free = !out_valid_reg || pix.ready;
    assign cmd.ready = cmd_ready_int;
    assign load_go   = cmd.valid && cmd_ready_int && (cmd.kind == ipdda_pkg::KIND_LOAD);
    assign step_go   = cmd.valid && cmd_ready_int && (cmd.kind == ipdda_pkg::KIND_STEP);
    assign done_go   = (state_reg == ipdda_pkg::ST_DONE) && slot_free;
    assign out_wr    = step_go || done_go;

    assign pix.valid       = out_valid_reg;
    assign pix.pixel_valid = out_pv_reg;
    assign pix.pixel_x     = out_x_reg;
    assign pix.pixel_y     = out_y_reg;
    assign pix.pixel_color = out_color_reg;
    assign pix.last_pixel  = out_last_reg;

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ipdda_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd_ready_int = 1'b0;
        case (state_reg)
            ipdda_pkg::ST_IDLE:
            begin
                cmd_ready_int = slot_free;
                if (cmd.valid && slot_free && cmd.kind == ipdda_pkg::KIND_LOAD)
                    state_next = ipdda_pkg::ST_PROJ;
            end
            ipdda_pkg::ST_PROJ:
            begin
                if (iss_pt_reg && iss_ph_reg == ipdda_pkg::PH_SIN)
                    state_next = ipdda_pkg::ST_DRAIN;
            end
            ipdda_pkg::ST_DRAIN: state_next = ipdda_pkg::ST_DIFF;
            ipdda_pkg::ST_DIFF:  state_next = ipdda_pkg::ST_ABS;
            ipdda_pkg::ST_ABS:   state_next = ipdda_pkg::ST_MAX;
            ipdda_pkg::ST_MAX:   state_next = ipdda_pkg::ST_DIV;
            ipdda_pkg::ST_DIV:
            begin
                if (cnt_last && div_sel_reg)
                    state_next = ipdda_pkg::ST_DONE;
            end
            ipdda_pkg::ST_DONE:
            begin
                if (slot_free)
                    state_next = ipdda_pkg::ST_IDLE;
            end
            default: state_next = ipdda_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        case (iss_ph_reg)
            ipdda_pkg::PH_X:   iss_ph_next = ipdda_pkg::PH_Y;
            ipdda_pkg::PH_Y:   iss_ph_next = ipdda_pkg::PH_Z;
            ipdda_pkg::PH_Z:   iss_ph_next = ipdda_pkg::PH_COS;
            ipdda_pkg::PH_COS: iss_ph_next = ipdda_pkg::PH_SIN;
            default:           iss_ph_next = ipdda_pkg::PH_X;
        endcase
    end

    // ---------------- shared multiplier ----------------
    assign cx2 = $signed({1'b0, (iss_pt_reg ? col1_reg : col0_reg), 1'b0})
               - $signed({1'b0, map_width_reg});
    assign cy2 = $signed({1'b0, (iss_pt_reg ? row1_reg : row0_reg), 1'b0})
               - $signed({1'b0, map_height_reg});

    always_comb
    begin
        case (iss_ph_reg)
            ipdda_pkg::PH_X:
            begin
                mul_a = $signed(MA_W'(xy_scale_reg));
                mul_b = MB_W'(cx2);
            end
            ipdda_pkg::PH_Y:
            begin
                mul_a = $signed(MA_W'(xy_scale_reg));
                mul_b = MB_W'(cy2);
            end
            ipdda_pkg::PH_Z:
            begin
                mul_a = MA_W'(height_scale_reg);
                mul_b = MB_W'(iss_pt_reg ? h1_reg : h0_reg);
            end
            ipdda_pkg::PH_COS:
            begin
                mul_a = dif_reg;
                mul_b = COS_C;
            end
            default:
            begin
                mul_a = sum_reg;
                mul_b = SIN_C;
            end
        endcase
    end

    assign sy    = $signed(prod_reg[SXY_W:1]);
    assign sz    = $signed(prod_reg[SZ_W-1:0]);
    assign acc_x = ACC_W'(prod_reg >>> FRAC_BITS) + (ACC_W'(off_x_reg) <<< FRAC_BITS);
    assign acc_y = ACC_W'(prod_reg >>> FRAC_BITS) + zo_reg;

    // ---------------- shared divider ----------------
    assign steps_ext = REM_W'(steps_reg);
    assign trial     = (cnt_reg == '0) ? rem_reg : {rem_reg[REM_W-2:0], 1'b0};
    assign ge        = trial >= steps_ext;
    assign rem_next  = ge ? trial - steps_ext : trial;
    assign quo_next  = (cnt_reg == '0) ? QUO_W'(ge) : {quo_reg[QUO_W-2:0], ge};
    assign cnt_last  = cnt_reg == CNT_W'(FRAC_BITS);
    assign q_signed  = $signed({1'b0, quo_reg});

    assign zero_len  = steps_reg == '0;
    assign n_raw     = steps_reg[MAG_W-1:FRAC_BITS];
    assign n_sat     = (n_raw > MAX_N) ? MAX_N : n_raw;
    assign pl_last   = pixels_left_reg <= PL_W'(1);

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_pt_reg      <= 1'b0;
            iss_ph_reg      <= ipdda_pkg::PH_X;
            prod_valid_reg  <= 1'b0;
            cnt_reg         <= '0;
            div_sel_reg     <= 1'b0;
            seg_active_reg  <= 1'b0;
            pixels_left_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= state_reg == ipdda_pkg::ST_PROJ;

            if (load_go)
            begin
                iss_pt_reg <= 1'b0;
                iss_ph_reg <= ipdda_pkg::PH_X;
            end
            else if (state_reg == ipdda_pkg::ST_PROJ)
            begin
                iss_ph_reg <= iss_ph_next;
                if (iss_ph_reg == ipdda_pkg::PH_SIN)
                    iss_pt_reg <= 1'b1;
            end

            if (state_reg == ipdda_pkg::ST_MAX)
            begin
                cnt_reg     <= '0;
                div_sel_reg <= 1'b0;
            end
            else if (state_reg == ipdda_pkg::ST_DIV)
            begin
                cnt_reg <= cnt_last ? '0 : cnt_reg + CNT_W'(1);
                if (cnt_last)
                    div_sel_reg <= 1'b1;
            end

            if (done_go)
            begin
                seg_active_reg  <= 1'b1;
                pixels_left_reg <= zero_len ? PL_W'(1) : PL_W'(n_sat) + PL_W'(1);
            end
            else if (step_go && seg_active_reg)
            begin
                if (pl_last)
                begin
                    seg_active_reg  <= 1'b0;
                    pixels_left_reg <= '0;
                end
                else
                    pixels_left_reg <= pixels_left_reg - PL_W'(1);
            end

            if (out_wr)
                out_valid_reg <= 1'b1;
            else if (pix.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (load_go)
        begin
            col0_reg     <= cmd.start_col;
            row0_reg     <= cmd.start_row;
            h0_reg       <= cmd.start_height;
            col1_reg     <= cmd.end_col;
            row1_reg     <= cmd.end_row;
            h1_reg       <= cmd.end_height;
            color_in_reg <= cmd.start_color;
        end

        prod_reg   <= PR_W'(mul_a) * PR_W'(mul_b);
        tag_pt_reg <= iss_pt_reg;
        tag_ph_reg <= iss_ph_reg;

        if (prod_valid_reg)
        begin
            case (tag_ph_reg)
                ipdda_pkg::PH_X: sx_reg <= sy;
                ipdda_pkg::PH_Y:
                begin
                    dif_reg <= MA_W'(sx_reg) - MA_W'(sy);
                    sum_reg <= MA_W'(sx_reg) + MA_W'(sy);
                end
                ipdda_pkg::PH_Z: zo_reg <= (ACC_W'(off_y_reg) <<< FRAC_BITS) - ACC_W'(sz);
                ipdda_pkg::PH_COS:
                begin
                    if (tag_pt_reg)
                        end_x_reg <= sat_crd(acc_x);
                    else
                        cursor_x_reg <= sat_crd(acc_x);
                end
                default:
                begin
                    if (tag_pt_reg)
                        end_y_reg <= sat_crd(acc_y);
                    else
                        cursor_y_reg <= sat_crd(acc_y);
                end
            endcase
        end
        else if (step_go && seg_active_reg)
        begin
            cursor_x_reg <= cursor_x_reg + CRD_W'(step_x_reg);
            cursor_y_reg <= cursor_y_reg + CRD_W'(step_y_reg);
        end

        if (state_reg == ipdda_pkg::ST_DIFF)
        begin
            dx_reg <= DIF_W'(end_x_reg) - DIF_W'(cursor_x_reg);
            dy_reg <= DIF_W'(end_y_reg) - DIF_W'(cursor_y_reg);
        end

        if (state_reg == ipdda_pkg::ST_ABS)
        begin
            neg_x_reg <= dx_reg[DIF_W-1];
            neg_y_reg <= dy_reg[DIF_W-1];
            ax_reg    <= MAG_W'(dx_reg[DIF_W-1] ? -dx_reg : dx_reg);
            ay_reg    <= MAG_W'(dy_reg[DIF_W-1] ? -dy_reg : dy_reg);
        end

        if (state_reg == ipdda_pkg::ST_MAX)
        begin
            steps_reg <= (ax_reg >= ay_reg) ? ax_reg : ay_reg;
            rem_reg   <= REM_W'(ax_reg);
        end
        else if (state_reg == ipdda_pkg::ST_DIV)
        begin
            rem_reg <= (cnt_last && !div_sel_reg) ? REM_W'(ay_reg) : rem_next;
            quo_reg <= quo_next;
            // x quotient is complete when the y pass starts
            if (div_sel_reg && cnt_reg == '0)
                step_x_reg <= neg_x_reg ? -q_signed : q_signed;
        end

        if (done_go)
        begin
            step_x_reg    <= zero_len ? '0 : step_x_reg;
            step_y_reg    <= zero_len ? '0 : (neg_y_reg ? -q_signed : q_signed);
            seg_color_reg <= zero_len ? ipdda_pkg::WHITE : color_in_reg;
        end

        if (out_wr)
        begin
            if (step_go && seg_active_reg)
            begin
                out_pv_reg    <= 1'b1;
                out_x_reg     <= trunc_px(cursor_x_reg);
                out_y_reg     <= trunc_px(cursor_y_reg);
                out_color_reg <= seg_color_reg;
                out_last_reg  <= pl_last;
            end
            else
            begin
                out_pv_reg    <= 1'b0;
                out_x_reg     <= '0;
                out_y_reg     <= '0;
                out_color_reg <= '0;
                out_last_reg  <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/ipdda_checker.sv =====
// ----------------------------------------------------------------------------
// ipdda_checker
// Port-level assertions for the isometric DDA line rasterizer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipdda_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                cmd_valid,
    input logic                                cmd_ready,
    input logic                                cmd_kind,
    input logic                                pix_valid,
    input logic                                pix_ready,
    input logic                                pix_pixel_valid,
    input logic signed [ipdda_pkg::PIX_W-1:0]  pix_pixel_x,
    input logic signed [ipdda_pkg::PIX_W-1:0]  pix_pixel_y,
    input logic [ipdda_pkg::COLOR_W-1:0]       pix_pixel_color,
    input logic                                pix_last_pixel
);

    `ASSERT_NEXT(a_result_held, clk, rst_n, pix_valid && !pix_ready, pix_valid)
    `ASSERT_IMPL(a_no_accept_when_full, clk, rst_n, pix_valid && !pix_ready, !cmd_ready)
    `ASSERT_NEXT(a_load_busy, clk, rst_n, cmd_valid && cmd_ready && cmd_kind == ipdda_pkg::KIND_LOAD, !cmd_ready)
    `ASSERT_IMPL(a_last_is_pixel, clk, rst_n, pix_valid && pix_last_pixel, pix_pixel_valid)
    `ASSERT_IMPL(a_empty_is_zero, clk, rst_n, pix_valid && !pix_pixel_valid, pix_pixel_x == '0 && pix_pixel_y == '0 && pix_pixel_color == '0)

endmodule

bind iso_projected_dda_line_rasterizer ipdda_checker u_ipdda_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .cmd_kind        (cmd.kind),
    .pix_valid       (pix.valid),
    .pix_ready       (pix.ready),
    .pix_pixel_valid (pix.pixel_valid),
    .pix_pixel_x     (pix.pixel_x),
    .pix_pixel_y     (pix.pixel_y),
    .pix_pixel_color (pix.pixel_color),
    .pix_last_pixel  (pix.last_pixel)
);
